/* hdl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, command and status types.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int WordWidth = 32;

   typedef logic [WordWidth-1:0] word_type;

   localparam word_type PadWord = 32'h8000_0000;

   typedef struct packed {
      logic     load_word;    // write word_data into the window, bump the count
      word_type word_data;
      logic     start_block;  // copy chain into working registers, clear round
      logic     do_round;     // run one round
      logic     finish_block; // add working registers into the chain
      logic     reset_chain;  // return to the initial state
      logic     add_len;      // add len_bits to the bit length
      logic [5:0] len_bits;
   } cmd_type;

   typedef struct packed {
      logic       round_last;
      logic [3:0] words_in_block;
      logic [63:0] bit_length;
   } stat_type;

   function automatic word_type init_hash(input logic [2:0] i);
      word_type r;
      r = '0;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = '0;
      endcase
      return r;
   endfunction

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

/* hdl/sha256_message_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Takes a message as big-endian 32-bit words and returns the eight-word digest.
// ----------------------------------------------------------------------------
// A request carries one message word; valid_bytes counts the valid bytes from
// the top and matters only with final_word set. A word that does not fill a
// block is stored and the hasher is ready again for the next request. The
// sixteenth word of a block starts a compression of one round per cycle: 64
// rounds, then the chain update in the add state. On the final word the
// controller adds the pad and length words one per cycle, running a second
// compression when the length does not fit. Eight responses follow, one per
// cycle while rsp_ready is high; a stalled receiver holds the current word and
// no request is taken until the last one goes. Reset returns the chain to the
// initial hash value and clears the length and counts.
// ----------------------------------------------------------------------------
module sha256_message_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_final_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   cmd_type    cmd;
   stat_type   stat;
   logic [2:0] rd_index;

   sha_control u_control (
      .clock, .reset, .req_valid, .req_ready, .req_data_word, .req_valid_bytes,
      .req_final_word, .rsp_valid, .rsp_ready, .rsp_word_index, .rsp_digest_last,
      .rd_index, .cmd, .stat
   );

   sha_datapath u_datapath (
      .clock, .reset, .cmd, .rd_index, .rd_word(rsp_digest_word), .stat
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken during digest output");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_digest_last |=> !rsp_valid && req_ready)
      else $error("no return to idle after digest");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index))
      else $error("response dropped while stalled");

endmodule

/* hdl/sha_datapath.sv */
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Schedule window, round registers, chaining value and bit length counter.
// ----------------------------------------------------------------------------
module sha_datapath
   import sha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [2:0] rd_index,
   output word_type   rd_word,
   output stat_type   stat
);

   word_type   chain_ff [8];
   word_type   chain_in [8];
   word_type   vars_ff [8];
   word_type   vars_in [8];
   word_type   win_ff [16];
   logic [3:0] count_ff, count_in;
   logic [5:0] round_ff, round_in;
   logic [63:0] len_ff, len_in;

   word_type wt, w2, w15, s0, s1, t1, t2, sched;
   logic [3:0] ri;

   assign ri  = round_ff[3:0];
   assign w2  = win_ff[ri - 4'd2];
   assign w15 = win_ff[ri - 4'd15];
   assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
   assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
   assign sched = s1 + win_ff[ri - 4'd7] + s0 + win_ff[ri];
   assign wt  = round_ff[5:4] == 2'd0 ? win_ff[ri] : sched;
   assign t1  = vars_ff[7] + (rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25))
              + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
              + RoundK[round_ff] + wt;
   assign t2  = (rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22))
              + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
              ^ (vars_ff[1] & vars_ff[2]));

   always_comb begin
      chain_in = chain_ff;
      vars_in  = vars_ff;
      count_in = count_ff;
      round_in = round_ff;
      len_in   = len_ff;
      if (cmd.add_len) begin
         len_in = len_ff + 64'(cmd.len_bits);
      end
      if (cmd.load_word) begin
         count_in = count_ff + 4'd1;
      end
      if (cmd.start_block) begin
         vars_in  = chain_ff;
         round_in = '0;
      end
      if (cmd.do_round) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
         round_in   = round_ff + 6'd1;
      end
      if (cmd.finish_block) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
      if (cmd.reset_chain) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = init_hash(3'(i));
            vars_in[i]  = '0;
         end
         count_in = '0;
         round_in = '0;
         len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= init_hash(3'(i));
            vars_ff[i]  <= '0;
         end
         count_ff <= '0;
         round_ff <= '0;
         len_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         vars_ff  <= vars_in;
         count_ff <= count_in;
         round_ff <= round_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         win_ff[count_ff] <= cmd.word_data;
      end else if (cmd.do_round && round_ff[5:4] != 2'd0) begin
         win_ff[ri] <= sched;
      end
   end

   assign rd_word = chain_ff[rd_index];
   assign stat.round_last     = round_ff == 6'd63;
   assign stat.words_in_block = count_ff;
   assign stat.bit_length     = len_ff;

endmodule

/* hdl/sha_control.sv */
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word loads, compressions, padding and digest output.
// ----------------------------------------------------------------------------
module sha_control
   import sha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  word_type   req_data_word,
   input  logic [2:0] req_valid_bytes,
   input  logic       req_final_word,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_word_index,
   output logic       rsp_digest_last,
   output logic [2:0] rd_index,
   output cmd_type    cmd,
   input  stat_type   stat
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StRound = 3'd1;
   localparam logic [2:0] StAdd   = 3'd2;
   localparam logic [2:0] StPad   = 3'd3;
   localparam logic [2:0] StOut   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;      // padding in progress
   logic [1:0] tail_ff, tail_in;    // 0 pad word, 1 zero fill, 2 len hi, 3 len lo
   logic [2:0] idx_ff, idx_in;
   logic [2:0] nb;
   word_type   keep, padded;
   logic       accept, push;

   assign nb     = (!req_final_word || req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
   assign keep   = nb == 3'd0 ? '0 : ~('1 >> {nb, 3'b000});
   assign padded = (req_data_word & keep) | (PadWord >> {nb, 3'b000});
   assign req_ready = state_ff == StIdle;
   assign accept = req_valid && req_ready;
   assign rsp_valid = state_ff == StOut;
   assign rsp_word_index  = idx_ff;
   assign rsp_digest_last = idx_ff == 3'd7;
   assign rd_index = idx_ff;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      tail_in  = tail_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      push     = 1'b0;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               cmd.add_len  = 1'b1;
               cmd.len_bits = {nb, 3'b000};
               cmd.load_word = 1'b1;
               push = 1'b1;
               if (req_final_word) begin
                  fin_in = 1'b1;
                  if (nb == 3'd4) begin
                     cmd.word_data = req_data_word;
                     tail_in = 2'd0;
                  end else begin
                     cmd.word_data = padded;
                     tail_in = 2'd1;
                  end
               end else begin
                  cmd.word_data = req_data_word;
               end
            end
         end
         StPad: begin
            cmd.load_word = 1'b1;
            push = 1'b1;
            case (tail_ff)
               2'd0: begin
                  cmd.word_data = PadWord;
                  tail_in = 2'd1;
               end
               2'd1: begin
                  if (stat.words_in_block == 4'd14) begin
                     cmd.word_data = stat.bit_length[63:32];
                     tail_in = 2'd3;
                  end else begin
                     cmd.word_data = '0;
                     if (stat.words_in_block == 4'd13) tail_in = 2'd2;
                  end
               end
               2'd2: begin
                  cmd.word_data = stat.bit_length[63:32];
                  tail_in = 2'd3;
               end
               default: begin
                  cmd.word_data = stat.bit_length[31:0];
               end
            endcase
         end
         StRound: begin
            cmd.do_round = 1'b1;
            if (stat.round_last) state_in = StAdd;
         end
         StAdd: begin
            cmd.finish_block = 1'b1;
            if (!fin_ff) begin
               state_in = StIdle;
            end else if (tail_ff == 2'd3) begin
               state_in = StOut;
               idx_in   = '0;
            end else begin
               state_in = StPad;
            end
         end
         StOut: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.reset_chain = 1'b1;
                  fin_in   = 1'b0;
                  state_in = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
      if (push) begin
         if (stat.words_in_block == 4'd15) begin
            cmd.start_block = 1'b1;
            state_in = StRound;
         end else if (fin_in) begin
            state_in = StPad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         fin_ff   <= 1'b0;
         tail_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         tail_ff  <= tail_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
